>>> rtl/ftsc_pkg.sv
// ----------------------------------------------------------------------------
// ftsc_pkg
// Shared constants and types for the frame-tick stopwatch / countdown timer.
// ----------------------------------------------------------------------------
package ftsc_pkg;

    localparam int FRAMES_PER_SECOND = 60;
    localparam int MAX_SECONDS       = 6000;
    localparam int SECS_PER_MIN      = 60;

    localparam int FRAME_W = 6;
    localparam int SEC_W   = 14;
    localparam int LIMIT_W = 13;
    localparam int ADDR_W  = 2;

    // register indexes on the config port
    localparam logic [ADDR_W-1:0] REG_LIMIT      = 2'd0;
    localparam logic [ADDR_W-1:0] REG_COUNT_DOWN = 2'd1;
    localparam logic [ADDR_W-1:0] REG_AUTO_PAUSE = 2'd2;

    // seconds / 60 by reciprocal: exact for every 14-bit count
    localparam int MIN_SHIFT = 20;
    localparam int MIN_RECIP = (2**MIN_SHIFT + SECS_PER_MIN - 1) / SECS_PER_MIN;
    localparam int MIN_PROD_W = 29;
    localparam int MIN_Q_W    = 9;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    // timer state right after one item
    typedef struct packed {
        logic [SEC_W-1:0]   sec;
        logic [FRAME_W-1:0] frame;
        logic               up;
        logic               hidden;
        logic               active;
    } t_snap;

endpackage

>>> rtl/ftsc_fmt.sv
// ----------------------------------------------------------------------------
// ftsc_fmt
// Display formatter: splits the second count into minutes and seconds and
// scales the frame count to hundredths. Two pipeline stages with stall.
// ----------------------------------------------------------------------------
module ftsc_fmt #(
    parameter int FRAMES_PER_SECOND = ftsc_pkg::FRAMES_PER_SECOND
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  ftsc_pkg::t_snap                 i_snap,
    output logic                            o_valid,
    input  logic                            i_ready,
    // minutes[6:0], seconds[12:7], hundredths[19:13], time_up[20],
    // display_hidden[21], running[22], zero[23]
    output logic [ftsc_pkg::OUT_DATA_W-1:0] o_data
);

    // frame * 100 / FPS as one constant multiply and a shift
    localparam int HUND_SHIFT = 19;
    localparam int HUND_MUL   = 100 * ((2**HUND_SHIFT + FRAMES_PER_SECOND - 1)
                                       / FRAMES_PER_SECOND);

    logic                               r_s2_valid;
    ftsc_pkg::t_snap                    r_s2_snap;
    logic [ftsc_pkg::MIN_Q_W-1:0]       r_s2_q;
    logic [6:0]                         r_s2_hund;
    logic                               r_s3_valid;
    logic [ftsc_pkg::OUT_DATA_W-1:0]    r_s3_data;

    logic                               w_en2;
    logic                               w_en3;
    logic [ftsc_pkg::MIN_PROD_W-1:0]    w_min_prod;
    logic [31:0]                        w_hund_prod;
    logic [ftsc_pkg::SEC_W-1:0]         w_q60;
    logic [ftsc_pkg::SEC_W-1:0]         w_rem;

    assign w_en3   = !r_s3_valid || i_ready;
    assign w_en2   = !r_s2_valid || w_en3;
    assign o_ready = w_en2;

    assign w_min_prod  = ftsc_pkg::MIN_PROD_W'(i_snap.sec)
                       * ftsc_pkg::MIN_PROD_W'(ftsc_pkg::MIN_RECIP);
    assign w_hund_prod = 32'(i_snap.frame) * 32'(HUND_MUL);

    assign w_q60 = ftsc_pkg::SEC_W'(r_s2_q) * ftsc_pkg::SEC_W'(ftsc_pkg::SECS_PER_MIN);
    assign w_rem = r_s2_snap.sec - w_q60;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_en2) begin
                r_s2_valid <= i_valid;
            end
            if (w_en3) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && i_valid) begin
            r_s2_snap <= i_snap;
            r_s2_q    <= w_min_prod[ftsc_pkg::MIN_SHIFT +: ftsc_pkg::MIN_Q_W];
            r_s2_hund <= w_hund_prod[HUND_SHIFT +: 7];
        end
        if (w_en3 && r_s2_valid) begin
            r_s3_data <= {1'b0, r_s2_snap.active, r_s2_snap.hidden, r_s2_snap.up,
                          r_s2_hund, w_rem[5:0], r_s2_q[6:0]};
        end
    end

    assign o_valid = r_s3_valid;
    assign o_data  = r_s3_data;

endmodule

>>> rtl/frame_tick_stopwatch_countdown.sv
// ----------------------------------------------------------------------------
// frame_tick_stopwatch_countdown
// Frame-tick stopwatch / countdown timer with minutes, seconds, hundredths.
// ----------------------------------------------------------------------------
// Each input beat is a start (tuser = 1) or one frame tick (tuser = 0) and
// yields exactly one output beat with the display after that beat. One beat
// is taken every clock cycle unless the output stalls; the timer state updates
// at acceptance and the result leaves through a stalling three-stage pipeline
// (state snapshot, reciprocal multiply for minutes and hundredths, seconds
// remainder). Config writes land at once and are meant for idle periods.
module frame_tick_stopwatch_countdown #(
    parameter int FRAMES_PER_SECOND = ftsc_pkg::FRAMES_PER_SECOND,
    parameter int MAX_SECONDS       = ftsc_pkg::MAX_SECONDS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // controls_locked[0], menu_open[1], manual_pause[2], zero[7:3]
    input  logic [ftsc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation[0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // minutes[6:0], seconds[12:7], hundredths[19:13], time_up[20],
    // display_hidden[21], running[22], zero[23]
    output logic [ftsc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [ftsc_pkg::ADDR_W-1:0]     i_cfg_addr,
    input  logic [ftsc_pkg::LIMIT_W-1:0]    i_cfg_wdata
);

    localparam int FW = ftsc_pkg::FRAME_W;
    localparam int SW = ftsc_pkg::SEC_W;

    logic [ftsc_pkg::LIMIT_W-1:0] r_limit;
    logic                         r_count_down;
    logic                         r_auto_pause;

    logic [FW-1:0] r_frame, n_frame;
    logic [SW-1:0] r_sec, n_sec;
    logic          r_active, n_active;
    logic          r_hidden, n_hidden;
    logic          n_up;

    logic            r_s1_valid;
    ftsc_pkg::t_snap r_s1;

    logic          w_accept;
    logic          w_fmt_ready;
    logic          w_locked, w_menu, w_mpause;
    logic          w_go;
    logic [FW-1:0] w_tk_frame;
    logic [SW-1:0] w_tk_sec;
    logic          w_tk_up;

    assign w_locked = s_axis_tdata[0];
    assign w_menu   = s_axis_tdata[1];
    assign w_mpause = s_axis_tdata[2];

    assign s_axis_tready = !r_s1_valid || w_fmt_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // one counting tick
    always_comb begin
        w_tk_frame = r_frame;
        w_tk_sec   = r_sec;
        w_tk_up    = 1'b0;
        if (r_count_down) begin
            if (r_frame == '0 || {1'b0, r_frame} >= (FW+1)'(FRAMES_PER_SECOND)) begin
                if (r_sec == '0) begin
                    w_tk_frame = '0;
                    w_tk_up    = 1'b1;
                end else begin
                    w_tk_frame = FW'(FRAMES_PER_SECOND - 1);
                    w_tk_sec   = r_sec - 1'b1;
                end
            end else begin
                w_tk_frame = r_frame - 1'b1;
            end
        end else begin
            if (r_frame >= FW'(FRAMES_PER_SECOND - 1)) begin
                w_tk_frame = '0;
                w_tk_sec   = r_sec + 1'b1;
            end else begin
                w_tk_frame = r_frame + 1'b1;
            end
            w_tk_up = w_tk_sec >= SW'(r_limit);
        end
    end

    // pause gating; hidden may be set even when the tick is held
    always_comb begin
        n_frame  = r_frame;
        n_sec    = r_sec;
        n_active = r_active;
        n_hidden = r_hidden;
        n_up     = 1'b0;
        w_go     = 1'b0;
        if (s_axis_tuser) begin
            n_sec    = r_count_down ? SW'(r_limit) : '0;
            n_frame  = '0;
            n_hidden = 1'b1;
            n_active = 1'b1;
        end else if (r_active) begin
            if (r_auto_pause) begin
                w_go = !w_locked;
                if (w_locked && w_menu) begin
                    n_hidden = 1'b1;
                end
            end else if (w_mpause) begin
                w_go = 1'b0;
            end else if (w_menu) begin
                n_hidden = 1'b1;
            end else begin
                w_go = 1'b1;
            end
            if (w_go) begin
                n_frame  = w_tk_frame;
                n_sec    = w_tk_sec;
                n_hidden = w_tk_up;
                n_up     = w_tk_up;
                n_active = !w_tk_up;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit      <= '0;
            r_count_down <= 1'b0;
            r_auto_pause <= 1'b0;
            r_frame      <= '0;
            r_sec        <= '0;
            r_active     <= 1'b0;
            r_hidden     <= 1'b1;
            r_s1_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    ftsc_pkg::REG_LIMIT: begin
                        r_limit <= (i_cfg_wdata > ftsc_pkg::LIMIT_W'(MAX_SECONDS))
                                 ? ftsc_pkg::LIMIT_W'(MAX_SECONDS) : i_cfg_wdata;
                    end
                    ftsc_pkg::REG_COUNT_DOWN: r_count_down <= i_cfg_wdata[0];
                    ftsc_pkg::REG_AUTO_PAUSE: r_auto_pause <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_frame  <= n_frame;
                r_sec    <= n_sec;
                r_active <= n_active;
                r_hidden <= n_hidden;
            end
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1.sec    <= n_sec;
            r_s1.frame  <= n_frame;
            r_s1.up     <= n_up;
            r_s1.hidden <= n_hidden;
            r_s1.active <= n_active;
        end
    end

    ftsc_fmt #(
        .FRAMES_PER_SECOND(FRAMES_PER_SECOND)
    ) u_fmt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (w_fmt_ready),
        .i_snap  (r_s1),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame-tick stopwatch / countdown timer. A
// tracker object predicts the display after every accepted beat and checks
// each output beat against the oldest prediction. A directed opening covers
// pause gating, restart and the time-up edges. Phases of random ticks follow
// under changing limit / direction / pause settings, with bursty input and a
// stalling receiver.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit OP_TICK  = 1'b0;
    localparam bit OP_START = 1'b1;

    // flag masks, in tdata bit order
    localparam logic [2:0] F_LOCKED = 3'b001;
    localparam logic [2:0] F_MENU   = 3'b010;
    localparam logic [2:0] F_MPAUSE = 3'b100;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 14;
    localparam int PHASE_BEATS = 110;

    typedef struct packed {
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic [6:0] hundredths;
        logic       time_up;
        logic       hidden;
        logic       running;
    } t_disp;

    class t_timer_tracker;
        logic [ftsc_pkg::LIMIT_W-1:0] limit;
        bit                           cnt_down;
        bit                           auto_pause;
        logic [ftsc_pkg::FRAME_W-1:0] frame;
        logic [ftsc_pkg::SEC_W-1:0]   sec;
        bit                           active;
        bit                           hidden;
        t_disp                        display_q[$];
        int                           n_in;
        int                           n_starts;
        int                           n_checked;
        int                           n_time_up;
        int                           n_err;

        function new();
            limit      = '0;
            cnt_down   = 0;
            auto_pause = 0;
            frame      = '0;
            sec        = '0;
            active     = 0;
            hidden     = 1;
        endfunction

        function void write_reg(logic [ftsc_pkg::ADDR_W-1:0] idx, int unsigned val);
            int unsigned v;
            v = val & 32'h1fff;
            if (idx == ftsc_pkg::REG_LIMIT)
                limit = (v > ftsc_pkg::MAX_SECONDS)
                      ? ftsc_pkg::LIMIT_W'(ftsc_pkg::MAX_SECONDS)
                      : ftsc_pkg::LIMIT_W'(v);
            else if (idx == ftsc_pkg::REG_COUNT_DOWN)
                cnt_down = val[0];
            else if (idx == ftsc_pkg::REG_AUTO_PAUSE)
                auto_pause = val[0];
        endfunction

        // one counting frame; returns 1 when time runs out
        function bit advance_frame();
            if (cnt_down) begin
                if (frame == 0 || frame >= ftsc_pkg::FRAMES_PER_SECOND) begin
                    if (sec == 0) begin
                        frame = '0;
                        return 1;
                    end
                    frame = ftsc_pkg::FRAME_W'(ftsc_pkg::FRAMES_PER_SECOND - 1);
                    sec   = sec - 1'b1;
                end else begin
                    frame = frame - 1'b1;
                end
                return 0;
            end
            if (frame >= ftsc_pkg::FRAMES_PER_SECOND - 1) begin
                frame = '0;
                sec   = sec + 1'b1;
            end else begin
                frame = frame + 1'b1;
            end
            return sec >= ftsc_pkg::SEC_W'(limit);
        endfunction

        function void note_beat(bit op, logic [2:0] flags);
            bit    go;
            bit    up;
            bit    locked;
            bit    menu;
            bit    mpause;
            t_disp e;
            locked = flags[0];
            menu   = flags[1];
            mpause = flags[2];
            up     = 0;
            n_in++;
            if (op == OP_START) begin
                sec    = cnt_down ? ftsc_pkg::SEC_W'(limit) : '0;
                frame  = '0;
                hidden = 1;
                active = 1;
                n_starts++;
            end else if (active) begin
                if (auto_pause) begin
                    go = !locked;
                    if (locked && menu)
                        hidden = 1;
                end else if (mpause) begin
                    go = 0;
                end else if (menu) begin
                    hidden = 1;
                    go     = 0;
                end else begin
                    go = 1;
                end
                if (go) begin
                    hidden = 0;
                    if (advance_frame()) begin
                        up     = 1;
                        active = 0;
                        hidden = 1;
                    end
                end
            end
            e.minutes    = 7'(int'(sec) / 60);
            e.seconds    = 6'(int'(sec) % 60);
            e.hundredths = 7'(int'(frame) * 100 / ftsc_pkg::FRAMES_PER_SECOND);
            e.time_up    = up;
            e.hidden     = hidden;
            e.running    = active;
            display_q.push_back(e);
        endfunction

        function void cmp_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                n_err++;
            end
        endfunction

        function void check_display(logic [ftsc_pkg::OUT_DATA_W-1:0] beat);
            t_disp e;
            if (display_q.size() == 0) begin
                $error("output beat 0x%06h with no prediction pending", beat);
                n_err++;
                return;
            end
            e = display_q.pop_front();
            n_checked++;
            if (beat[20])
                n_time_up++;
            cmp_field("minutes", e.minutes, beat[6:0]);
            cmp_field("seconds", e.seconds, beat[12:7]);
            cmp_field("hundredths", e.hundredths, beat[19:13]);
            cmp_field("time_up", e.time_up, beat[20]);
            cmp_field("display_hidden", e.hidden, beat[21]);
            cmp_field("running", e.running, beat[22]);
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // controls_locked[0], menu_open[1], manual_pause[2]
    logic [ftsc_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tuser;   // operation[0]
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // minutes, seconds, hundredths, time_up, hidden, running
    logic [ftsc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            i_cfg_we;
    logic [ftsc_pkg::ADDR_W-1:0]     i_cfg_addr;
    logic [ftsc_pkg::LIMIT_W-1:0]    i_cfg_wdata;

    t_timer_tracker tracker = new();
    int             burst_left;
    int             cycles;

    frame_tick_stopwatch_countdown dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_display(m_axis_tdata);
    end

    // receiver: segments of different stall patterns, plus one long hold-off
    initial begin
        int  seg_left;
        int  mode;
        int  k;
        bit  held;
        seg_left = 0;
        mode     = 0;
        k        = 0;
        held     = 0;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!held && tracker.n_in >= 200) begin
                held = 1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 200);
                    mode     = $urandom_range(0, 3);
                end
                seg_left--;
                k++;
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (k % 4 == 0);
                    default: m_axis_tready <= (k % 5 != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(input bit op, input logic [2:0] flags);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, flags};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_beat(op, flags);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (tracker.display_q.size() != 0)
            @(posedge i_clk);
        // pipeline is already empty here; settle with the input idle before returning
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned lim, input bit down, input bit autop);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= ftsc_pkg::REG_LIMIT;
        i_cfg_wdata <= ftsc_pkg::LIMIT_W'(lim);
        @(posedge i_clk);
        tracker.write_reg(ftsc_pkg::REG_LIMIT, lim);
        i_cfg_addr  <= ftsc_pkg::REG_COUNT_DOWN;
        i_cfg_wdata <= ftsc_pkg::LIMIT_W'(down);
        @(posedge i_clk);
        tracker.write_reg(ftsc_pkg::REG_COUNT_DOWN, down);
        i_cfg_addr  <= ftsc_pkg::REG_AUTO_PAUSE;
        i_cfg_wdata <= ftsc_pkg::LIMIT_W'(autop);
        @(posedge i_clk);
        tracker.write_reg(ftsc_pkg::REG_AUTO_PAUSE, autop);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [2:0] rand_flags();
        logic [2:0] f;
        f = '0;
        if ($urandom_range(0, 5) == 0) f |= F_LOCKED;
        if ($urandom_range(0, 7) == 0) f |= F_MENU;
        if ($urandom_range(0, 7) == 0) f |= F_MPAUSE;
        return f;
    endfunction

    initial begin
        int unsigned lim;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        burst_left    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // count up to one second, manual pause rules
        set_config(1, 1'b0, 1'b0);
        send_beat(OP_TICK, F_LOCKED | F_MENU | F_MPAUSE);   // stopped: no change
        send_beat(OP_START, '0);
        send_beat(OP_TICK, F_MPAUSE);
        send_beat(OP_TICK, F_MENU);
        send_beat(OP_TICK, F_MENU | F_MPAUSE);
        send_beat(OP_TICK, '0);
        send_beat(OP_TICK, F_LOCKED);
        send_beat(OP_START, F_LOCKED | F_MENU | F_MPAUSE);  // restart while running
        send_beat(OP_TICK, '0);

        // oversize limit clamps; countdown with auto pause
        set_config(8191, 1'b1, 1'b1);
        send_beat(OP_START, '0);
        send_beat(OP_TICK, F_LOCKED | F_MENU);
        send_beat(OP_TICK, F_LOCKED);
        send_beat(OP_TICK, F_MENU);
        send_beat(OP_TICK, F_MPAUSE);

        // countdown from zero runs out on the first tick
        set_config(0, 1'b1, 1'b0);
        send_beat(OP_START, '0);
        send_beat(OP_TICK, '0);
        send_beat(OP_TICK, '0);

        // count up to zero runs out on the first tick
        set_config(0, 1'b0, 1'b0);
        send_beat(OP_START, '0);
        send_beat(OP_TICK, '0);

        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 9))
                0: lim = 0;
                1: lim = ftsc_pkg::MAX_SECONDS;
                2: lim = 8191;
                3: lim = $urandom_range(0, 8191);
                default: lim = $urandom_range(1, 3);
            endcase
            // first and last phase pin the extremes
            if (p == 0) lim = 6000;
            if (p == PHASES - 1) lim = 8191;
            set_config(lim, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            // mostly start fresh; otherwise keep the old count under new settings
            if ($urandom_range(0, 3) != 0)
                send_beat(OP_START, rand_flags());
            for (int i = 0; i < PHASE_BEATS; i++) begin
                if ($urandom_range(0, 79) == 0)
                    send_beat(OP_START, rand_flags());
                else
                    send_beat(OP_TICK, rand_flags());
            end
        end

        s_axis_tvalid <= 1'b0;
        while (tracker.display_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d beats (%0d starts) over %0d random phases.",
                 tracker.n_in, tracker.n_starts, PHASES);
        $display("Checked %0d display beats, %0d of them with time up.",
                 tracker.n_checked, tracker.n_time_up);
        if (tracker.n_err == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
rtl/ftsc_pkg.sv
rtl/ftsc_fmt.sv
rtl/frame_tick_stopwatch_countdown.sv
test/tb_top.sv
